/* sv/xfd_pkg.sv */
// ----------------------------------------------------------------------------
// xfd_pkg
// Shared types and codes for the XOR frame deframer: result word layout,
// status codes, result kinds and configuration register indexes.
// ----------------------------------------------------------------------------
package xfd_pkg;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_START = 2'd1;
  localparam logic [1:0] ST_CKSUM_ERR = 2'd2;
  localparam logic [1:0] ST_BAD_END   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_START_MARKER    = 2'd0;
  localparam logic [1:0] REG_END_MARKER      = 2'd1;
  localparam logic [1:0] REG_CHECKSUM_ENABLE = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0] START_MARKER_RST = 8'd170;
  localparam logic [7:0] END_MARKER_RST   = 8'd85;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* sv/xfd_front.sv */
// ----------------------------------------------------------------------------
// xfd_front
// Accepts link bytes, tracks the frame phase and running XOR, holds the
// configuration registers and pushes one result word per producing byte.
// ----------------------------------------------------------------------------
module xfd_front
  import xfd_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  q_status_t  q_stat,
  output logic       push,
  output result_t    push_word
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CMD      = 3'd1;
  localparam logic [2:0] PH_LEN_LO   = 3'd2;
  localparam logic [2:0] PH_LEN_HI   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_CKSUM    = 3'd5;
  localparam logic [2:0] PH_END_CK   = 3'd6;
  localparam logic [2:0] PH_END_NOCK = 3'd7;

  logic [7:0]             start_marker;
  logic [7:0]             end_marker;
  logic                   checksum_enable;

  logic [2:0]             phase, phase_next;
  logic [7:0]             length_low_byte, length_low_byte_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [15:0]            byte_position, byte_position_next;
  logic [7:0]             running_xor, running_xor_next;
  logic [7:0]             received_checksum, received_checksum_next;

  logic                   fire;
  logic [15:0]            len_full;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [2:0]             after_data;
  logic                   end_bad;

  assign in_ready  = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  assign len_full   = {rx_byte, length_low_byte};
  assign len        = len_full[LENGTH_BITS-1:0];
  assign rem_dec    = bytes_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign after_data = checksum_enable ? PH_CKSUM : PH_END_NOCK;
  assign end_bad    = (rx_byte != end_marker);

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker    <= START_MARKER_RST;
      end_marker      <= END_MARKER_RST;
      checksum_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_MARKER:    start_marker    <= cfg_data;
        REG_END_MARKER:      end_marker      <= cfg_data;
        REG_CHECKSUM_ENABLE: checksum_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify the byte and form the result word
  always_comb begin
    phase_next             = phase;
    length_low_byte_next   = length_low_byte;
    bytes_remaining_next   = bytes_remaining;
    byte_position_next     = byte_position;
    running_xor_next       = running_xor;
    received_checksum_next = received_checksum;
    push                   = 1'b0;
    push_word              = '0;
    push_word.kind         = KIND_STATUS;
    push_word.last         = 1'b1;
    if (fire) begin
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte != start_marker) begin
            push             = 1'b1;
            push_word.status = ST_BAD_START;
          end else begin
            running_xor_next     = '0;
            byte_position_next   = '0;
            bytes_remaining_next = '0;
            phase_next           = PH_CMD;
          end
        end
        PH_CMD: begin
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          running_xor_next     = running_xor ^ rx_byte;
          length_low_byte_next = rx_byte;
          phase_next           = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          running_xor_next     = running_xor ^ rx_byte;
          bytes_remaining_next = len;
          byte_position_next   = '0;
          phase_next           = (len == '0) ? after_data : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_xor_next     = running_xor ^ rx_byte;
          push                 = 1'b1;
          push_word.kind       = KIND_PAYLOAD;
          push_word.data       = rx_byte;
          push_word.index      = byte_position;
          push_word.last       = 1'b0;
          byte_position_next   = byte_position + 16'd1;
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = after_data;
          end
        end
        PH_CKSUM: begin
          received_checksum_next = rx_byte;
          phase_next             = PH_END_CK;
        end
        PH_END_CK: begin
          // checksum mismatch wins over a bad end byte
          phase_next = PH_IDLE;
          push       = 1'b1;
          if (received_checksum != running_xor) begin
            push_word.status = ST_CKSUM_ERR;
          end else begin
            push_word.status = end_bad ? ST_BAD_END : ST_OK;
          end
        end
        PH_END_NOCK: begin
          phase_next       = PH_IDLE;
          push             = 1'b1;
          push_word.status = end_bad ? ST_BAD_END : ST_OK;
        end
        default: ;
      endcase
    end
  end

  // advance the parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
    length_low_byte   <= length_low_byte_next;
    bytes_remaining   <= bytes_remaining_next;
    byte_position     <= byte_position_next;
    running_xor       <= running_xor_next;
    received_checksum <= received_checksum_next;
  end

endmodule

/* sv/xfd_queue.sv */
// ----------------------------------------------------------------------------
// xfd_queue
// Two-entry result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module xfd_queue
  import xfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  result_t   push_word,
  input  logic      pop,
  output result_t   head_word,
  output q_status_t q_stat
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_word    = entries[rd_ptr];

  // store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/xfd_back.sv */
// ----------------------------------------------------------------------------
// xfd_back
// Output stage: pulls result words from the queue into the output register
// and presents them on the result channel.
// ----------------------------------------------------------------------------
module xfd_back
  import xfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_status_t   q_stat,
  input  result_t     head_word,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [1:0]  frame_status,
  output logic        frame_last
);

  result_t out_word;

  // load when the register is free or its word is taken
  assign pop = (!out_valid || out_ready) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !q_stat.empty;
    end
    if (pop) begin
      out_word <= head_word;
    end
  end

  assign result_kind   = out_word.kind;
  assign payload_byte  = out_word.data;
  assign payload_index = out_word.index;
  assign frame_status  = out_word.status;
  assign frame_last    = out_word.last;

endmodule

/* sv/xor_frame_deframer_top.sv */
// A result word enters the queue at the edge that accepts its byte, then the output register.
// Throughput: one byte per cycle when the queue is not full; phase and XOR update in that cycle.
// A two-entry queue and an output register decouple the parser from the result channel.
// Reset (rst, synchronous): parser returns to idle, queue and output empty,
// registers back to start 170, end 85, checksum enabled.
// ----------------------------------------------------------------------------
// xor_frame_deframer_top
// Length-prefixed frame parser with XOR checksum: parser front, result
// queue and output stage.
// ----------------------------------------------------------------------------
module xor_frame_deframer_top
  import xfd_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [1:0]  frame_status,
  output logic        frame_last
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  result_t   push_word;
  result_t   head_word;

  // parse incoming bytes
  xfd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  // buffer result words
  xfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  // drive the result channel
  xfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .head_word     (head_word),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_status  (frame_status),
    .frame_last    (frame_last)
  );

endmodule
